[hdl/cbrf_pkg.sv]
`timescale 1ns / 1ps
// shared constants and codes for the cubic bisection root finder
// no dependencies

package cbrf_pkg;

  localparam int DATA_W          = 32;  // bracket ends and root, signed fixed point
  localparam int TOL_W           = 24;  // tolerance register width
  localparam int STATUS_W        = 2;
  localparam int FRACTION_BITS_D = 24;
  localparam int ITERATION_BITS_D = 10;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(168);

  // f(x) = x^3 + 4x^2 - 10
  localparam int QUAD_SHIFT  = 2;   // coefficient 4 of the square term
  localparam int CONST_TERM  = 10;  // constant term, integer part

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 2'd0,
    ST_NO_CHANGE = 2'd1,
    ST_LIMIT     = 2'd2
  } status_t;

endpackage

[hdl/cubic_bisection_root_finder.sv]
`timescale 1ns / 1ps
// bisection root finder for f(x) = x^3 + 4x^2 - 10 on a signed fixed-point bracket
// depends on cbrf_pkg
//
// usage:
//   s_* channel carries one bracket per transaction: left end, right end and an
//   iteration limit n. at most n-1 bisection steps run; the search stops early when
//   |f(midpoint)| is at or below the tolerance register.
//   m_* channel returns one result per bracket: last midpoint, status
//   (found / no sign change / limit reached) and the number of steps taken.
//   cfg_* channel writes the tolerance register (lsbs of the fixed-point format);
//   write it only while no bracket is in flight.
// schedule:
//   every evaluation of f runs on one shared 32x32 multiplier in the steps abs,
//   square, two partial products of the cube, sum and compare. the two bracket
//   ends are evaluated first; each bisection step then forms the midpoint and
//   runs one more evaluation. s_tready rises with m_tvalid of the result, so the
//   next bracket is taken only once the result is out; s_tready is low while a
//   bracket is being worked on.
// reset: rst (synchronous) idles the sequencer, drops m_tvalid and sets tolerance
//   to 168.
// stall: the result sits in an output register; if the previous result has not
//   been taken yet, the sequencer waits in its done state until it is.

module cubic_bisection_root_finder
  import cbrf_pkg::*;
#(
  parameter int FRACTION_BITS  = FRACTION_BITS_D,
  parameter int ITERATION_BITS = ITERATION_BITS_D,
  localparam int IN_W  = ((2 * DATA_W + ITERATION_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((DATA_W + STATUS_W + ITERATION_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // left_end, right_end, max_iterations, zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // root, status, steps_used, zero pad
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOL_W-1:0] cfg_data   // tolerance
);

  localparam int SQ_W    = 2 * DATA_W - FRACTION_BITS;       // x^2 after truncation
  localparam int PROD_W  = 3 * DATA_W - FRACTION_BITS;       // x^2 * |x| before shift
  localparam int CUBE_W  = PROD_W - FRACTION_BITS;
  localparam int VAL_W   = 3 * DATA_W + 2 - 2 * FRACTION_BITS; // signed f(x)
  localparam int CNT_W   = ITERATION_BITS + 1;
  localparam logic signed [VAL_W-1:0] TEN_FIX = VAL_W'(CONST_TERM) << FRACTION_BITS;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LD   = 9'b000000010,
    S_SQ   = 9'b000000100,
    S_LO   = 9'b000001000,
    S_HI   = 9'b000010000,
    S_VAL  = 9'b000100000,
    S_CHK  = 9'b001000000,
    S_MID  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    PH_A = 3'b001,
    PH_B = 3'b010,
    PH_C = 3'b100
  } phase_t;

  state_t state;
  phase_t phase;

  logic [TOL_W-1:0]          tolerance;
  logic signed [DATA_W-1:0]  a, b, x;
  logic [ITERATION_BITS-1:0] n, steps;
  logic signed [DATA_W-1:0]  root;
  status_t                   status;
  logic                      sa_neg, sa_zero;

  // evaluation datapath
  logic                      neg;
  logic [DATA_W-1:0]         mag;
  logic [SQ_W-1:0]           sq;
  logic [2*DATA_W-1:0]       acc;
  logic [PROD_W-1:0]         prod;
  logic signed [VAL_W-1:0]   term, val;

  logic signed [DATA_W-1:0]  out_root;
  status_t                   out_status;
  logic [ITERATION_BITS-1:0] out_steps;

  // shared multiplier
  logic [DATA_W-1:0]         mul_a;
  logic [2*DATA_W-1:0]       mul_out;

  always_comb begin
    case (state)
      S_LO:    mul_a = sq[DATA_W-1:0];
      S_HI:    mul_a = DATA_W'(sq[SQ_W-1:DATA_W]);
      default: mul_a = mag;
    endcase
  end

  assign mul_out = mul_a * mag;

  // result of the evaluation, valid in S_CHK
  logic                     f_neg, f_zero, f_small;
  logic signed [VAL_W-1:0]  tol_pos;
  logic [CUBE_W-1:0]        cube;
  logic [VAL_W-1:0]         cube_ext;
  logic                     frac_zero;
  logic                     same_sign, opposite_sign;
  logic [DATA_W:0]          mid_sum;
  logic [ITERATION_BITS-1:0] steps_next;
  logic                     more_steps;

  assign tol_pos   = $signed(VAL_W'(tolerance));
  assign f_neg     = val[VAL_W-1];
  assign f_zero    = (val == '0);
  assign f_small   = (val <= tol_pos) && (val >= -tol_pos);
  assign cube      = prod[PROD_W-1:FRACTION_BITS];
  assign cube_ext  = VAL_W'(cube);
  assign frac_zero = (prod[FRACTION_BITS-1:0] == '0);

  assign same_sign     = !sa_zero && !f_zero && (sa_neg == f_neg);
  assign opposite_sign = !sa_zero && !f_zero && (sa_neg != f_neg);
  assign mid_sum       = {a[DATA_W-1], a} + {b[DATA_W-1], b};
  assign steps_next    = steps + ITERATION_BITS'(1);
  assign more_steps    = (CNT_W'(steps_next) + CNT_W'(1)) < CNT_W'(n);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = OUT_W'({out_steps, out_status, out_root});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_A;
      m_tvalid  <= 1'b0;
      tolerance <= TOL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tolerance <= cfg_data;
      end
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            phase <= PH_A;
            state <= S_LD;
          end
        end
        S_LD:  state <= S_SQ;
        S_SQ:  state <= S_LO;
        S_LO:  state <= S_HI;
        S_HI:  state <= S_VAL;
        S_VAL: state <= S_CHK;
        S_CHK: begin
          unique case (phase)
            PH_A: begin
              phase <= PH_B;
              state <= S_LD;
            end
            PH_B: begin
              if (same_sign || n <= ITERATION_BITS'(1)) begin
                state <= S_DONE;
              end else begin
                phase <= PH_C;
                state <= S_MID;
              end
            end
            PH_C: begin
              if (f_small || !more_steps) begin
                state <= S_DONE;
              end else begin
                state <= S_MID;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_MID: state <= S_LD;
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          a      <= s_tdata[DATA_W-1:0];
          b      <= s_tdata[2*DATA_W-1:DATA_W];
          x      <= s_tdata[DATA_W-1:0];
          n      <= s_tdata[2*DATA_W+ITERATION_BITS-1:2*DATA_W];
          steps  <= '0;
          root   <= '0;
          status <= ST_LIMIT;
        end
      end
      S_LD: begin
        neg <= x[DATA_W-1];
        mag <= x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
      end
      S_SQ: sq <= mul_out[2*DATA_W-1:FRACTION_BITS];
      S_LO: begin
        acc  <= mul_out;
        term <= $signed(VAL_W'(sq) << QUAD_SHIFT) - TEN_FIX;
      end
      S_HI: prod <= (PROD_W'(mul_out) << DATA_W) + PROD_W'(acc);
      // negative x: floor of the cube, so -(cube+1) when fraction bits were dropped
      S_VAL: val <= $signed(neg ? ~cube_ext : cube_ext) + term
                    + $signed(VAL_W'(neg && frac_zero));
      S_CHK: begin
        unique case (phase)
          PH_A: begin
            sa_neg  <= f_neg;
            sa_zero <= f_zero;
            x       <= b;
          end
          PH_B: begin
            if (same_sign) begin
              status <= ST_NO_CHANGE;
            end
          end
          PH_C: begin
            steps <= steps_next;
            root  <= x;
            if (opposite_sign) begin
              b <= x;
            end else begin
              a       <= x;
              sa_neg  <= f_neg;
              sa_zero <= f_zero;
            end
            if (f_small) begin
              status <= ST_FOUND;
            end
          end
          default: ;
        endcase
      end
      S_MID: x <= $signed(mid_sum[DATA_W:1]);
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_root   <= root;
          out_status <= status;
          out_steps  <= steps;
        end
      end
      default: ;
    endcase
  end

  // a bisection step is only evaluated while the limit still allows it
  a_step_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK && phase == PH_C) |-> (CNT_W'(steps) + CNT_W'(1)) < CNT_W'(n))
    else $error("bisection step beyond iteration limit");

  // no sign change reports a zero root and no steps
  a_no_change: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_NO_CHANGE) |-> (out_root == '0 && out_steps == '0))
    else $error("no-sign-change result carries a root or steps");

  // a found root needs at least one step
  a_found_steps: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_FOUND) |-> (out_steps != '0))
    else $error("root found without a bisection step");

  // the input side only opens once the previous result has left the sequencer
  a_done_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!m_tvalid || m_tready)) |=> (m_tvalid && state == S_IDLE))
    else $error("result not handed to output register");

endmodule

[sim/tb_cubic_bisection_root_finder.sv]
`timescale 1ns / 1ps
// self-checking bench for cubic_bisection_root_finder: random and directed brackets,
// tolerance sweeps, random stalls on both streams and a long output hold-off
// depends on cbrf_pkg and the root finder rtl

module tb_cubic_bisection_root_finder;
  import cbrf_pkg::*;

  localparam int IN_W  = ((2 * DATA_W + ITERATION_BITS_D + 7) / 8) * 8;
  localparam int OUT_W = ((DATA_W + STATUS_W + ITERATION_BITS_D + 7) / 8) * 8;
  localparam int HOLDOFF_CYCLES = 3000;

  // q8.24 points around the single real root (about 1.36523)
  localparam logic signed [31:0] ONE        = 32'sh01000000;
  localparam longint             ROOT_BELOW = 22817013;  // 1.36, f < 0
  localparam longint             ROOT_ABOVE = 22984786;  // 1.37, f > 0
  localparam longint             ROOT_GUESS = 22904761;
  localparam longint             INT_MIN    = -64'sh80000000;
  localparam longint             INT_MAX    = 64'sh7FFFFFFF;

  typedef struct {
    logic signed [31:0]           left_end;
    logic signed [31:0]           right_end;
    logic [ITERATION_BITS_D-1:0]  max_iterations;
  } bracket_t;

  typedef struct {
    logic signed [31:0]           root;
    status_t                      status;
    logic [ITERATION_BITS_D-1:0]  steps;
  } root_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;

  bracket_t         pending_brackets[$];
  root_result_t     expected_roots[$];
  bracket_t         offered;
  root_result_t     want;
  logic [TOL_W-1:0] tolerance_setting = TOL_RESET;
  int               total_queued = 0;
  int               brackets_taken = 0;
  int               results_seen = 0;
  int               errors = 0;
  int               holdoff_left = 0;
  longint           cycle_count = 0;
  longint           cycle_limit = 300000 + 8 * HOLDOFF_CYCLES;

  cubic_bisection_root_finder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // sign of x^3 + 4x^2 - 10 with products floored to the fraction width
  function automatic int cubic_sign(input logic signed [63:0] x, input logic [TOL_W-1:0] tol,
                                    output bit near_zero);
    logic [63:0]  mag;
    logic [63:0]  sq;
    logic [127:0] prod;
    logic [127:0] cube;
    logic [127:0] val;
    mag = (x < 0) ? -x : x;
    sq = (mag * mag) >> FRACTION_BITS_D;
    prod = {64'd0, sq} * {96'd0, mag[31:0]};
    cube = prod >> FRACTION_BITS_D;
    if (x < 0) begin
      // floor of a negative cube rounds the magnitude up
      if (prod[FRACTION_BITS_D-1:0] != '0) cube = cube + 128'd1;
      cube = -cube;
    end
    val = cube + {64'd0, sq << QUAD_SHIFT} - (128'(CONST_TERM) << FRACTION_BITS_D);
    if (val[127]) begin
      near_zero = (-val) <= {104'd0, tol};
      return -1;
    end
    near_zero = val <= {104'd0, tol};
    return (val != '0) ? 1 : 0;
  endfunction

  function automatic root_result_t solve_bracket(input bracket_t br,
                                                 input logic [TOL_W-1:0] tol);
    logic signed [63:0] lo_end;
    logic signed [63:0] hi_end;
    logic signed [63:0] mid;
    int                 s_lo;
    int                 s_hi;
    int                 s_mid;
    bit                 near;
    bit                 unused;
    root_result_t       r;
    lo_end = br.left_end;
    hi_end = br.right_end;
    r.root = '0;
    r.status = ST_LIMIT;
    r.steps = '0;
    s_lo = cubic_sign(lo_end, tol, unused);
    s_hi = cubic_sign(hi_end, tol, unused);
    if (s_lo * s_hi > 0) begin
      r.status = ST_NO_CHANGE;
      return r;
    end
    for (int i = 1; i < br.max_iterations; i++) begin
      mid = (lo_end + hi_end) >>> 1;
      s_lo = cubic_sign(lo_end, tol, unused);
      s_mid = cubic_sign(mid, tol, near);
      r.steps = r.steps + 1'b1;
      // an exact zero at either end counts as no sign change, so the left end moves
      if (s_lo * s_mid < 0) hi_end = mid;
      else lo_end = mid;
      r.root = mid[31:0];
      if (near) begin
        r.status = ST_FOUND;
        return r;
      end
    end
    return r;
  endfunction

  task automatic queue_bracket(input logic signed [31:0] lo, input logic signed [31:0] hi,
                               input logic [ITERATION_BITS_D-1:0] n);
    bracket_t br;
    br.left_end = lo;
    br.right_end = hi;
    br.max_iterations = n;
    pending_brackets.push_back(br);
    total_queued++;
    cycle_limit += 4 * (13 + 7 * longint'(n) + 60);
  endtask

  task automatic add_random_brackets(input int count);
    int                          pick;
    int                          r;
    longint                      lo_w;
    longint                      hi_w;
    longint                      swap_w;
    longint                      span;
    logic [ITERATION_BITS_D-1:0] n;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, 99);
      if (r < 80) n = ITERATION_BITS_D'($urandom_range(0, 48));
      else if (r < 95) n = ITERATION_BITS_D'($urandom_range(49, 200));
      else n = ITERATION_BITS_D'($urandom_range(201, 1023));
      if (pick < 65) begin
        // bracket around the root, span of random magnitude on each side
        span = longint'($urandom >> $urandom_range(0, 31));
        lo_w = ROOT_BELOW - span;
        span = longint'($urandom >> $urandom_range(0, 31));
        hi_w = ROOT_ABOVE + span;
        if (lo_w < INT_MIN) lo_w = INT_MIN;
        if (hi_w > INT_MAX) hi_w = INT_MAX;
        if ($urandom_range(0, 1)) begin
          swap_w = lo_w;
          lo_w = hi_w;
          hi_w = swap_w;
        end
        queue_bracket(lo_w[31:0], hi_w[31:0], n);
      end else if (pick < 88) begin
        queue_bracket($urandom, $urandom, n);
      end else begin
        // both ends on one side of the root
        span = longint'($urandom >> $urandom_range(0, 31));
        lo_w = $urandom_range(0, 1) ? ROOT_ABOVE + span : ROOT_BELOW - span;
        span = longint'($urandom >> $urandom_range(0, 31));
        hi_w = (lo_w > ROOT_GUESS) ? ROOT_ABOVE + span : ROOT_BELOW - span;
        if (lo_w < INT_MIN) lo_w = INT_MIN;
        if (lo_w > INT_MAX) lo_w = INT_MAX;
        if (hi_w < INT_MIN) hi_w = INT_MIN;
        if (hi_w > INT_MAX) hi_w = INT_MAX;
        queue_bracket(lo_w[31:0], hi_w[31:0], n);
      end
    end
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tolerance_setting = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    wait (results_seen == total_queued);
    repeat (20) @(posedge clk);
  endtask

  // sender: holds an offered bracket until taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_roots.push_back(solve_bracket(offered, tolerance_setting));
        brackets_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_brackets.size() > 0 &&
            ((brackets_taken >= 200 && brackets_taken < 300) || $urandom_range(0, 99) >= 15)) begin
          offered = pending_brackets.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= IN_W'({offered.max_iterations, offered.right_end, offered.left_end});
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: m_tdata = root, status, steps_used from bit 0 up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: result with none expected: root %0d status %0d steps %0d", $time,
                   $signed(m_tdata[31:0]), m_tdata[33:32], m_tdata[43:34]);
          errors++;
        end else begin
          want = expected_roots.pop_front();
          if ($signed(m_tdata[31:0]) !== want.root) begin
            $display("%0t: root expected %0d got %0d", $time, want.root,
                     $signed(m_tdata[31:0]));
            errors++;
          end
          if (m_tdata[33:32] !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, m_tdata[33:32]);
            errors++;
          end
          if (m_tdata[43:34] !== want.steps) begin
            $display("%0t: steps_used expected %0d got %0d", $time, want.steps,
                     m_tdata[43:34]);
            errors++;
          end
        end
        results_seen++;
        // long hold-off so the block parks a result and stops taking brackets
        if (results_seen == 50 || results_seen == 350) holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (results_seen >= 200 && results_seen < 300) || $urandom_range(0, 99) >= 15;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("cubic_bisection_root_finder: mismatch");
      $finish;
    end
  end

  initial begin
    longint probe;
    longint zero_at;
    bit     probe_near;
    bit     have_zero;
    have_zero = 1'b0;
    zero_at = 0;
    // look for a point where the truncated cubic is exactly zero
    for (probe = ROOT_GUESS - 2000; probe <= ROOT_GUESS + 2000; probe++) begin
      if (!have_zero && cubic_sign(probe, '0, probe_near) == 0) begin
        zero_at = probe;
        have_zero = 1'b1;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed brackets under the reset tolerance
    queue_bracket(ONE, 2 * ONE, 1023);
    queue_bracket(2 * ONE, ONE, 1023);
    queue_bracket(ONE, 2 * ONE, 0);
    queue_bracket(ONE, 2 * ONE, 1);
    queue_bracket(ONE, 2 * ONE, 2);
    queue_bracket(ONE, 2 * ONE, 5);
    queue_bracket(0, ONE, 1023);
    queue_bracket(2 * ONE, 3 * ONE, 0);
    queue_bracket(32'sh80000000, 32'sh7FFFFFFF, 1023);
    queue_bracket(32'sh7FFFFFFF, 32'sh80000000, 1023);
    queue_bracket(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1023);
    queue_bracket(32'sh80000000, 32'sh80000000, 1023);
    queue_bracket(32'sh80000000, 2 * ONE, 600);
    queue_bracket(32'(ROOT_BELOW), 32'(ROOT_ABOVE), 1023);
    queue_bracket(32'(ROOT_BELOW), 32'(ROOT_BELOW + 1), 1023);
    queue_bracket(-3 * ONE, 2 * ONE, 40);
    queue_bracket(0, 0, 0);
    queue_bracket(-1, 2 * ONE, 10);
    queue_bracket(32'sh7FFFFFFF, 0, 10'h155);
    queue_bracket(0, 32'sh7FFFFFFF, 10'h2AA);
    if (have_zero) begin
      queue_bracket(zero_at[31:0], 2 * ONE, 40);
      queue_bracket(0, zero_at[31:0], 40);
    end
    add_random_brackets(90);
    drain_results();

    write_tolerance('0);
    add_random_brackets(100);
    drain_results();

    write_tolerance('1);
    add_random_brackets(100);
    drain_results();

    write_tolerance(TOL_W'($urandom_range(1, 4000)));
    add_random_brackets(100);
    drain_results();

    write_tolerance(TOL_W'($urandom));
    add_random_brackets(100);
    drain_results();

    write_tolerance(TOL_RESET);
    add_random_brackets(110);
    drain_results();

    if (errors == 0 && expected_roots.size() == 0) begin
      $display("cubic_bisection_root_finder: match");
    end else begin
      $display("cubic_bisection_root_finder: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/cbrf_pkg.sv
hdl/cubic_bisection_root_finder.sv
sim/tb_cubic_bisection_root_finder.sv
